// ===== rtl/core/node_pool_allocator_ordered_list_top_assert.svh =====
// Assertion macros for the node pool allocator checker.
// Both expect signals named clock and reset in the calling scope.
`ifndef NODE_POOL_ALLOCATOR_ORDERED_LIST_TOP_ASSERT_SVH
`define NODE_POOL_ALLOCATOR_ORDERED_LIST_TOP_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define NPA_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define NPA_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/npa_pkg.sv =====
`timescale 1ns / 1ps

package npa_pkg;

   localparam int ID_W   = 7;
   localparam int TYPE_W = 2;
   localparam int STAT_W = 2;

   localparam logic [ID_W-1:0] MAX_NODES_RESET = 7'd64;

   typedef enum logic [TYPE_W-1:0] {
      REQ_ALLOC  = 2'd0,
      REQ_FREE   = 2'd1,
      REQ_LOOKUP = 2'd2
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_BAD  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ALLOC,
      S_LINK,
      S_RESOLVE
   } seq_state_type;

   typedef struct packed {
      logic find;
      logic set;
      logic clear;
   } slot_ctl_type;

endpackage

// ===== rtl/core/npa_if.sv =====
`timescale 1ns / 1ps

interface npa_req_if import npa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TYPE_W-1:0] req_type;
   logic [ID_W-1:0]   node_id;

   modport source (output valid, output req_type, output node_id, input ready);
   modport sink   (input valid, input req_type, input node_id, output ready);
endinterface

interface npa_rsp_if import npa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [ID_W-1:0]   result_id;
   logic [ID_W-1:0]   prev_id;
   logic [ID_W-1:0]   next_id;
   logic [ID_W-1:0]   used_count;
   logic [ID_W-1:0]   head_id;
   logic [ID_W-1:0]   tail_id;

   modport source (output valid, output status, output result_id, output prev_id,
                   output next_id, output used_count, output head_id, output tail_id,
                   input ready);
   modport sink   (input valid, input status, input result_id, input prev_id,
                   input next_id, input used_count, input head_id, input tail_id,
                   output ready);
endinterface

interface npa_csr_if import npa_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] max_nodes;

   modport source (output valid, output max_nodes, input ready);
   modport sink   (input valid, input max_nodes, output ready);
endinterface

// ===== rtl/core/npa_link_ram.sv =====
`timescale 1ns / 1ps

module npa_link_ram import npa_pkg::*; #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  logic            clock,
   input  logic            we,
   input  logic [AW-1:0]   waddr,
   input  logic [ID_W-1:0] wdata,
   input  logic            re,
   input  logic [AW-1:0]   raddr,
   output logic [ID_W-1:0] rdata
);

   logic [ID_W-1:0] mem_ff [DEPTH];
   logic [ID_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/npa_slot_map.sv =====
`timescale 1ns / 1ps

module npa_slot_map import npa_pkg::*; #(
   parameter int POOL_SLOTS = 64,
   parameter int IDX_W      = 6
) (
   input  logic             clock,
   input  logic             reset,
   input  slot_ctl_type     ctl,
   input  logic [IDX_W-1:0] upd_idx,
   input  logic [IDX_W-1:0] query_idx,
   input  logic [ID_W-1:0]  lim,
   output logic             query_used,
   output logic             free_ok,
   output logic [IDX_W-1:0] free_idx
);

   localparam int NGRP  = (POOL_SLOTS + 7) / 8;
   localparam int GRP_W = (NGRP > 1) ? $clog2(NGRP) : 1;
   localparam int SW    = GRP_W + 3;
   localparam int CW    = (SW > ID_W) ? SW : ID_W;
   localparam int PAD   = NGRP * 8;

   logic [POOL_SLOTS-1:0] used_ff, used_in;
   logic [PAD-1:0]        padded;
   logic [NGRP-1:0]       grp_full;
   logic [GRP_W-1:0]      grp_sel;
   logic                  grp_any;
   logic [GRP_W-1:0]      grp_ff, grp_in;
   logic                  grp_ok_ff, grp_ok_in;
   logic [7:0]            bits;
   logic [2:0]            off;
   logic                  bit_any;
   logic [SW-1:0]         slot;

   // slots past the pool read as used
   always_comb begin
      padded = '1;
      padded[POOL_SLOTS-1:0] = used_ff;
   end

   always_comb begin
      for (int g = 0; g < NGRP; g++) begin
         grp_full[g] = &padded[g*8 +: 8];
      end
   end

   always_comb begin
      grp_sel = '0;
      grp_any = 1'b0;
      for (int g = NGRP - 1; g >= 0; g--) begin
         if (!grp_full[g]) begin
            grp_sel = GRP_W'(g);
            grp_any = 1'b1;
         end
      end
   end

   always_comb begin
      grp_in    = grp_ff;
      grp_ok_in = grp_ok_ff;
      if (ctl.find) begin
         grp_in    = grp_sel;
         grp_ok_in = grp_any;
      end
   end

   // second level: lowest free slot within the registered group
   always_comb begin
      bits    = padded[{grp_ff, 3'b000} +: 8];
      off     = '0;
      bit_any = 1'b0;
      for (int b = 7; b >= 0; b--) begin
         if (!bits[b]) begin
            off     = 3'(b);
            bit_any = 1'b1;
         end
      end
   end

   assign slot     = {grp_ff, off};
   assign free_ok  = grp_ok_ff && bit_any && (CW'(slot) < CW'(lim));
   assign free_idx = slot[IDX_W-1:0];

   assign query_used = used_ff[query_idx];

   always_comb begin
      used_in = used_ff;
      if (ctl.set) begin
         used_in[upd_idx] = 1'b1;
      end else if (ctl.clear) begin
         used_in[upd_idx] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         grp_ff    <= '0;
         grp_ok_ff <= 1'b0;
      end else begin
         used_ff   <= used_in;
         grp_ff    <= grp_in;
         grp_ok_ff <= grp_ok_in;
      end
   end

endmodule

// ===== rtl/core/node_pool_allocator_ordered_list_top.sv =====
`timescale 1ns / 1ps
// Channel   Port      Dir  Contents
// request   req_ch    in   req_type, node_id
// result    rsp_ch    out  status, result_id, prev_id, next_id, used_count, head_id, tail_id
// config    csr_ch    in   max_nodes (always ready)
//
// Allocate steps through free-group search, free-slot pick with new-node link writes,
// then the write of the old tail's next link. Free and lookup issue the link-memory
// read on acceptance and resolve on its registered data. One request is in flight at a time.
// Reset clears the used flags, list head, tail and count; no clearing pass.
// A finished result waits in its last state while the output register is still held.

module node_pool_allocator_ordered_list_top import npa_pkg::*; #(
   parameter int POOL_SLOTS = 64
) (
   input  logic    clock,
   input  logic    reset,
   npa_req_if.sink   req_ch,
   npa_rsp_if.source rsp_ch,
   npa_csr_if.sink   csr_ch
);

   localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
   localparam int AW    = (IDX_W > ID_W) ? IDX_W : ID_W;
   localparam logic [ID_W-1:0] POOL_CAP = (POOL_SLOTS > 127) ? 7'd127 : ID_W'(POOL_SLOTS);

   function automatic logic [IDX_W-1:0] id_idx(input logic [ID_W-1:0] id);
      logic [AW-1:0] w;
      w = AW'(id) - AW'(1);
      return w[IDX_W-1:0];
   endfunction

   seq_state_type     state_ff, state_in;
   logic [TYPE_W-1:0] type_ff, type_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [ID_W-1:0]   max_nodes_ff, max_nodes_in;
   logic [ID_W-1:0]   head_ff, head_in;
   logic [ID_W-1:0]   tail_ff, tail_in;
   logic [ID_W-1:0]   count_ff, count_in;
   logic [ID_W-1:0]   alloc_prev_ff, alloc_prev_in;
   logic [ID_W-1:0]   alloc_id_ff, alloc_id_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [ID_W-1:0]   rsp_result_ff, rsp_result_in;
   logic [ID_W-1:0]   rsp_prev_ff, rsp_prev_in;
   logic [ID_W-1:0]   rsp_next_ff, rsp_next_in;
   logic [ID_W-1:0]   rsp_count_ff, rsp_count_in;
   logic [ID_W-1:0]   rsp_head_ff, rsp_head_in;
   logic [ID_W-1:0]   rsp_tail_ff, rsp_tail_in;
   logic              rsp_load;

   logic [ID_W-1:0]   lim;
   logic              accept;
   logic              out_free;
   logic              id_ok;

   slot_ctl_type      slot_ctl;
   logic [IDX_W-1:0]  slot_upd_idx;
   logic              query_used;
   logic              free_ok;
   logic [IDX_W-1:0]  free_idx;
   logic [ID_W-1:0]   new_id;

   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              prev_we, next_we;
   logic [IDX_W-1:0]  prev_waddr, next_waddr;
   logic [ID_W-1:0]   prev_wdata, next_wdata;
   logic [ID_W-1:0]   prev_rd, next_rd;

   assign lim      = (max_nodes_ff > POOL_CAP) ? POOL_CAP : max_nodes_ff;
   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign new_id   = ID_W'(free_idx) + ID_W'(1);
   assign rd_addr  = id_idx(req_ch.node_id);

   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;
   assign max_nodes_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.max_nodes : max_nodes_ff;

   assign id_ok = (type_ff == REQ_FREE || type_ff == REQ_LOOKUP) && (id_ff != '0) &&
                  (id_ff <= lim) && query_used;

   npa_slot_map #(
      .POOL_SLOTS(POOL_SLOTS),
      .IDX_W     (IDX_W)
   ) u_slot_map (
      .clock     (clock),
      .reset     (reset),
      .ctl       (slot_ctl),
      .upd_idx   (slot_upd_idx),
      .query_idx (id_idx(id_ff)),
      .lim       (lim),
      .query_used(query_used),
      .free_ok   (free_ok),
      .free_idx  (free_idx)
   );

   npa_link_ram #(.DEPTH(POOL_SLOTS), .AW(IDX_W)) u_prev_ram (
      .clock(clock),
      .we   (prev_we),
      .waddr(prev_waddr),
      .wdata(prev_wdata),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(prev_rd)
   );

   npa_link_ram #(.DEPTH(POOL_SLOTS), .AW(IDX_W)) u_next_ram (
      .clock(clock),
      .we   (next_we),
      .waddr(next_waddr),
      .wdata(next_wdata),
      .re   (rd_en),
      .raddr(rd_addr),
      .rdata(next_rd)
   );

   always_comb begin
      state_in      = state_ff;
      type_in       = type_ff;
      id_in         = id_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      alloc_prev_in = alloc_prev_ff;
      alloc_id_in   = alloc_id_ff;

      slot_ctl      = '0;
      slot_upd_idx  = free_idx;
      rd_en         = 1'b0;
      prev_we       = 1'b0;
      prev_waddr    = free_idx;
      prev_wdata    = tail_ff;
      next_we       = 1'b0;
      next_waddr    = free_idx;
      next_wdata    = '0;

      rsp_load      = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_result_in = '0;
      rsp_prev_in   = '0;
      rsp_next_in   = '0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               type_in      = req_ch.req_type;
               id_in        = req_ch.node_id;
               slot_ctl.find = 1'b1;
               rd_en        = 1'b1;
               state_in     = (req_ch.req_type == REQ_ALLOC) ? S_ALLOC : S_RESOLVE;
            end
         end

         S_ALLOC: begin
            if (free_ok) begin
               slot_ctl.set  = 1'b1;
               prev_we       = 1'b1;
               next_we       = 1'b1;
               alloc_prev_in = tail_ff;
               alloc_id_in   = new_id;
               if (tail_ff == '0) begin
                  head_in = new_id;
               end
               tail_in  = new_id;
               count_in = count_ff + ID_W'(1);
               state_in = S_LINK;
            end else if (out_free) begin
               rsp_load      = 1'b1;
               rsp_status_in = ST_FULL;
               state_in      = S_IDLE;
            end
         end

         S_LINK: begin
            if (out_free) begin
               // hook the new node behind the old tail
               next_we       = (alloc_prev_ff != '0);
               next_waddr    = id_idx(alloc_prev_ff);
               next_wdata    = alloc_id_ff;
               rsp_load      = 1'b1;
               rsp_status_in = ST_OK;
               rsp_result_in = alloc_id_ff;
               rsp_prev_in   = alloc_prev_ff;
               state_in      = S_IDLE;
            end
         end

         S_RESOLVE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               if (!id_ok) begin
                  rsp_status_in = ST_BAD;
               end else if (type_ff == REQ_LOOKUP) begin
                  rsp_status_in = ST_OK;
                  rsp_result_in = id_ff;
                  rsp_prev_in   = prev_rd;
                  rsp_next_in   = next_rd;
               end else begin
                  // unlink: splice neighbors around the freed node
                  rsp_status_in  = ST_OK;
                  slot_ctl.clear = 1'b1;
                  slot_upd_idx   = id_idx(id_ff);
                  if (prev_rd != '0) begin
                     next_we    = 1'b1;
                     next_waddr = id_idx(prev_rd);
                     next_wdata = next_rd;
                  end else begin
                     head_in = next_rd;
                  end
                  if (next_rd != '0) begin
                     prev_we    = 1'b1;
                     prev_waddr = id_idx(next_rd);
                     prev_wdata = prev_rd;
                  end else begin
                     tail_in = prev_rd;
                  end
                  if (count_ff != '0) begin
                     count_in = count_ff - ID_W'(1);
                  end
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_count_in = rsp_load ? count_in : rsp_count_ff;
      rsp_head_in  = rsp_load ? head_in  : rsp_head_ff;
      rsp_tail_in  = rsp_load ? tail_in  : rsp_tail_ff;
      if (!rsp_load) begin
         rsp_result_in = rsp_result_ff;
         rsp_prev_in   = rsp_prev_ff;
         rsp_next_in   = rsp_next_ff;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         max_nodes_ff <= MAX_NODES_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         max_nodes_ff <= max_nodes_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      id_ff         <= id_in;
      alloc_prev_ff <= alloc_prev_in;
      alloc_id_ff   <= alloc_id_in;
      rsp_status_ff <= rsp_status_in;
      rsp_result_ff <= rsp_result_in;
      rsp_prev_ff   <= rsp_prev_in;
      rsp_next_ff   <= rsp_next_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_head_ff   <= rsp_head_in;
      rsp_tail_ff   <= rsp_tail_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.result_id  = rsp_result_ff;
   assign rsp_ch.prev_id    = rsp_prev_ff;
   assign rsp_ch.next_id    = rsp_next_ff;
   assign rsp_ch.used_count = rsp_count_ff;
   assign rsp_ch.head_id    = rsp_head_ff;
   assign rsp_ch.tail_id    = rsp_tail_ff;

endmodule

// ===== rtl/core/npa_checker.sv =====
`timescale 1ns / 1ps
`include "node_pool_allocator_ordered_list_top_assert.svh"

module npa_checker import npa_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [STAT_W-1:0] rsp_status,
   input logic [ID_W-1:0]   rsp_result_id,
   input logic [ID_W-1:0]   rsp_prev_id,
   input logic [ID_W-1:0]   rsp_next_id,
   input logic [ID_W-1:0]   rsp_used_count,
   input logic [ID_W-1:0]   rsp_head_id,
   input logic [ID_W-1:0]   rsp_tail_id
);

   `NPA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_result_id), "stalled result item changed")

   `NPA_ASSERT_NEXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request item accepted while one is in flight")

   `NPA_ASSERT_NOW(a_err_zero, rsp_valid && rsp_status != ST_OK, rsp_result_id == '0 && rsp_prev_id == '0 && rsp_next_id == '0, "error result carries node ids")

   `NPA_ASSERT_NOW(a_empty_list, rsp_valid && rsp_used_count == '0, rsp_head_id == '0 && rsp_tail_id == '0, "empty pool reports a list end")

   `NPA_ASSERT_NOW(a_no_self_link, rsp_valid && rsp_result_id != '0, rsp_prev_id != rsp_result_id && rsp_next_id != rsp_result_id, "node links to itself")

endmodule

bind node_pool_allocator_ordered_list_top npa_checker u_npa_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_status    (rsp_ch.status),
   .rsp_result_id (rsp_ch.result_id),
   .rsp_prev_id   (rsp_ch.prev_id),
   .rsp_next_id   (rsp_ch.next_id),
   .rsp_used_count(rsp_ch.used_count),
   .rsp_head_id   (rsp_ch.head_id),
   .rsp_tail_id   (rsp_ch.tail_id)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import npa_pkg::*;

   localparam int POOL_DEPTH     = 64;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int N_PHASES       = 10;

   // request code that the package leaves unnamed; the block rejects it
   localparam logic [TYPE_W-1:0] REQ_UNDEF = 2'd3;

   typedef enum logic [1:0] {
      ACT_REQ,
      ACT_CFG,
      ACT_SYNC
   } step_kind_t;

   typedef struct packed {
      step_kind_t       act;
      logic [TYPE_W-1:0] kind;
      logic [ID_W-1:0]   operand;
      logic              bursty;
   } step_t;

   typedef struct packed {
      status_type      status;
      logic [ID_W-1:0] result_id;
      logic [ID_W-1:0] prev_id;
      logic [ID_W-1:0] next_id;
      logic [ID_W-1:0] used_count;
      logic [ID_W-1:0] head_id;
      logic [ID_W-1:0] tail_id;
   } pool_result_t;

   logic clock = 1'b0;
   logic reset;

   npa_req_if req_if ();
   npa_rsp_if rsp_if ();
   npa_csr_if csr_if ();

   node_pool_allocator_ordered_list_top #(.POOL_SLOTS(POOL_DEPTH)) u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the pool
   bit              in_use    [POOL_DEPTH];
   logic [ID_W-1:0] back_link [POOL_DEPTH];
   logic [ID_W-1:0] fwd_link  [POOL_DEPTH];
   logic [ID_W-1:0] order_head;
   logic [ID_W-1:0] order_tail;
   logic [ID_W-1:0] live_count;
   logic [ID_W-1:0] node_limit;

   step_t        pending_items [$];
   pool_result_t owed_results  [$];

   int   issued_cnt = 0;
   int   seen_cnt = 0;
   int   fail_cnt = 0;
   int   quiet_cycles = 0;
   int   gap_left = 0;
   int   stall_left = 0;
   logic burst_enable = 1'b1;
   logic req_hold, csr_hold, req_go, csr_go;
   step_t        step;
   pool_result_t want;

   function automatic pool_result_t apply_pool_request(logic [TYPE_W-1:0] kind,
                                                       logic [ID_W-1:0] id);
      pool_result_t    r;
      int              lim;
      int              slot;
      logic [ID_W-1:0] p;
      logic [ID_W-1:0] n;
      r = '0;
      lim = (node_limit > POOL_DEPTH) ? POOL_DEPTH : int'(node_limit);
      if (kind == REQ_ALLOC) begin
         slot = 0;
         while (slot < lim && in_use[slot]) slot++;
         if (slot >= lim) begin
            r.status = ST_FULL;
         end else begin
            in_use[slot]    = 1'b1;
            back_link[slot] = order_tail;
            fwd_link[slot]  = '0;
            if (order_tail != 0) fwd_link[order_tail - 1] = ID_W'(slot + 1);
            else order_head = ID_W'(slot + 1);
            order_tail  = ID_W'(slot + 1);
            live_count  = live_count + 1'b1;
            r.status    = ST_OK;
            r.result_id = ID_W'(slot + 1);
            r.prev_id   = back_link[slot];
         end
      end else if (kind == REQ_UNDEF || id == 0 || id > lim || !in_use[id - 1]) begin
         r.status = ST_BAD;
      end else if (kind == REQ_LOOKUP) begin
         r.status    = ST_OK;
         r.result_id = id;
         r.prev_id   = back_link[id - 1];
         r.next_id   = fwd_link[id - 1];
      end else begin
         // unlink, then clear the slot
         p = back_link[id - 1];
         n = fwd_link[id - 1];
         if (p != 0) fwd_link[p - 1] = n;
         else order_head = n;
         if (n != 0) back_link[n - 1] = p;
         else order_tail = p;
         in_use[id - 1]    = 1'b0;
         back_link[id - 1] = '0;
         fwd_link[id - 1]  = '0;
         if (live_count != 0) live_count = live_count - 1'b1;
         r.status = ST_OK;
      end
      r.used_count = live_count;
      r.head_id    = order_head;
      r.tail_id    = order_tail;
      return r;
   endfunction

   task automatic check_field(string label, logic [ID_W-1:0] exp_val,
                              logic [ID_W-1:0] got_val);
      if (got_val !== exp_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d",
                  $time, label, exp_val, got_val);
         fail_cnt++;
      end
   endtask

   task automatic add_req(logic [TYPE_W-1:0] kind, logic [ID_W-1:0] id, logic bursty);
      pending_items.push_back('{ACT_REQ, kind, id, bursty});
   endtask

   task automatic add_cfg(logic [ID_W-1:0] limit_val);
      pending_items.push_back('{ACT_CFG, REQ_ALLOC, limit_val, 1'b1});
   endtask

   task automatic add_sync();
      pending_items.push_back('{ACT_SYNC, REQ_ALLOC, '0, 1'b1});
   endtask

   // driver: request and register channels, predicts at acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         csr_if.valid <= 1'b0;
         gap_left = 0;
         foreach (in_use[s]) begin
            in_use[s]    = 1'b0;
            back_link[s] = '0;
            fwd_link[s]  = '0;
         end
         order_head = '0;
         order_tail = '0;
         live_count = '0;
         node_limit = MAX_NODES_RESET;
      end else begin
         if (csr_if.valid && csr_if.ready) node_limit = csr_if.max_nodes;
         if (req_if.valid && req_if.ready) begin
            owed_results.push_back(apply_pool_request(req_if.req_type, req_if.node_id));
            issued_cnt++;
         end
         req_hold = req_if.valid && !req_if.ready;
         csr_hold = csr_if.valid && !csr_if.ready;
         req_go   = req_hold;
         csr_go   = csr_hold;
         if (!req_hold && !csr_hold) begin
            if (gap_left != 0) begin
               gap_left--;
            end else if (pending_items.size() != 0) begin
               step = pending_items[0];
               case (step.act)
                  ACT_REQ: begin
                     void'(pending_items.pop_front());
                     req_if.req_type <= step.kind;
                     req_if.node_id  <= step.operand;
                     req_go = 1'b1;
                     burst_enable <= step.bursty;
                     if (step.bursty && $urandom_range(0, 3) == 0)
                        gap_left = $urandom_range(1, 7);
                  end
                  ACT_CFG: begin
                     // write the limit only once every owed result is back
                     if (issued_cnt == seen_cnt) begin
                        void'(pending_items.pop_front());
                        csr_if.max_nodes <= step.operand;
                        csr_go = 1'b1;
                     end
                  end
                  default: begin
                     if (issued_cnt == seen_cnt) void'(pending_items.pop_front());
                  end
               endcase
            end
         end
         req_if.valid <= req_go;
         csr_if.valid <= csr_go;
      end
   end

   // monitor: result channel
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            seen_cnt <= seen_cnt + 1;
            if (owed_results.size() == 0) begin
               $display("%0t: unexpected result: expected none, actual status %0d id %0d",
                        $time, rsp_if.status, rsp_if.result_id);
               fail_cnt++;
            end else begin
               want = owed_results.pop_front();
               check_field("status", ID_W'(want.status), ID_W'(rsp_if.status));
               check_field("result_id", want.result_id, rsp_if.result_id);
               check_field("prev_id", want.prev_id, rsp_if.prev_id);
               check_field("next_id", want.next_id, rsp_if.next_id);
               check_field("used_count", want.used_count, rsp_if.used_count);
               check_field("head_id", want.head_id, rsp_if.head_id);
               check_field("tail_id", want.tail_id, rsp_if.tail_id);
            end
         end
         if (stall_left != 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= 1'b1;
            if (burst_enable && $urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 7);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("== FAIL ==");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_ctl
      logic [ID_W-1:0]   phase_limits [N_PHASES];
      logic [ID_W-1:0]   lim_val;
      logic [ID_W-1:0]   id;
      logic [TYPE_W-1:0] kind;
      int                span;
      int                alloc_pct;
      int                roll;
      int                n_items;
      logic              quiet;

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.req_type  = '0;
      req_if.node_id   = '0;
      csr_if.valid     = 1'b0;
      csr_if.max_nodes = '0;
      rsp_if.ready     = 1'b0;

      // directed: bad ids, list head/middle/tail unlink, limit extremes
      add_req(REQ_LOOKUP, 7'd0, 1'b1);
      add_req(REQ_FREE, 7'd0, 1'b1);
      add_req(REQ_LOOKUP, 7'd127, 1'b1);
      add_req(REQ_UNDEF, 7'd127, 1'b1);
      add_req(REQ_LOOKUP, 7'd64, 1'b1);
      add_req(REQ_ALLOC, 7'd127, 1'b1);
      add_req(REQ_ALLOC, 7'd0, 1'b1);
      add_req(REQ_ALLOC, 7'd85, 1'b1);
      add_req(REQ_LOOKUP, 7'd2, 1'b1);
      add_req(REQ_FREE, 7'd2, 1'b1);
      add_req(REQ_LOOKUP, 7'd1, 1'b1);
      add_req(REQ_UNDEF, 7'd1, 1'b1);
      add_req(REQ_FREE, 7'd1, 1'b1);
      add_req(REQ_FREE, 7'd3, 1'b1);
      add_req(REQ_FREE, 7'd3, 1'b1);
      add_req(REQ_ALLOC, 7'd42, 1'b1);
      add_cfg(7'd1);
      add_req(REQ_ALLOC, 7'd0, 1'b1);
      add_req(REQ_LOOKUP, 7'd1, 1'b1);
      add_cfg(7'd0);
      add_req(REQ_ALLOC, 7'd0, 1'b1);
      add_req(REQ_LOOKUP, 7'd1, 1'b1);
      add_req(REQ_FREE, 7'd1, 1'b1);
      add_cfg(7'd127);
      add_req(REQ_ALLOC, 7'd0, 1'b1);
      add_req(REQ_FREE, 7'd1, 1'b1);
      add_req(REQ_LOOKUP, 7'd2, 1'b1);

      phase_limits = '{7'd5, 7'd64, 7'd1, 7'd127, ID_W'($urandom_range(2, 63)), 7'd0,
                       7'd40, 7'd3, ID_W'($urandom_range(65, 126)), 7'd64};
      for (int ph = 0; ph < N_PHASES; ph++) begin
         lim_val = phase_limits[ph];
         add_cfg(lim_val);
         quiet     = (ph == N_PHASES - 1) || ($urandom_range(0, 4) == 0);
         alloc_pct = $urandom_range(25, 60);
         span      = (lim_val == 0) ? 1 : ((lim_val > POOL_DEPTH) ? POOL_DEPTH : lim_val);
         n_items   = (lim_val == 0) ? 15 : 68;
         for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct) kind = REQ_ALLOC;
            else if (roll < 95) kind = ($urandom_range(0, 4) < 3) ? REQ_FREE : REQ_LOOKUP;
            else kind = REQ_UNDEF;
            // mostly ids inside the active range, where used nodes live
            if (kind == REQ_ALLOC || $urandom_range(0, 9) == 0)
               id = ID_W'($urandom_range(0, 127));
            else
               id = ID_W'($urandom_range(1, span));
            add_req(kind, id, !quiet);
            if ($urandom_range(0, 49) == 0) add_sync();
         end
      end
      add_sync();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_cnt == 0 && owed_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
